// ----- hw/rtl/vprq_pkg.sv -----
// ----------------------------------------------------------------------------
// vprq_pkg
// types and fixed widths shared by the packet ring queue files
// ----------------------------------------------------------------------------
package vprq_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;

  typedef enum logic [1:0] {
    FN_OPEN   = 2'd0,
    FN_PUSH   = 2'd1,
    FN_POP    = 2'd2,
    FN_FINISH = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SLOT  = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_EOS      = 3'd4,
    ST_SEQ      = 3'd5
  } status_t;

endpackage

// ----- hw/rtl/vprq_in_if.sv -----
// ----------------------------------------------------------------------------
// vprq_in_if
// command word channel of the packet ring queue
// ----------------------------------------------------------------------------
interface vprq_in_if;
  logic                         valid;
  logic                         ready;
  vprq_pkg::func_t              func;
  logic [vprq_pkg::BYTE_W-1:0]  data_byte;
  logic [vprq_pkg::LEN_W-1:0]   packet_length;

  modport source (output valid, output func, output data_byte, output packet_length,
                  input ready);
  modport sink   (input valid, input func, input data_byte, input packet_length,
                  output ready);
endinterface

// ----- hw/rtl/vprq_out_if.sv -----
// ----------------------------------------------------------------------------
// vprq_out_if
// result word channel of the packet ring queue
// ----------------------------------------------------------------------------
interface vprq_out_if;
  logic                         valid;
  logic                         ready;
  vprq_pkg::status_t            status;
  logic [vprq_pkg::BYTE_W-1:0]  read_byte;
  logic [vprq_pkg::LEN_W-1:0]   popped_length;
  logic                         last_of_packet;

  modport source (output valid, output status, output read_byte, output popped_length,
                  output last_of_packet, input ready);
  modport sink   (input valid, input status, input read_byte, input popped_length,
                  input last_of_packet, output ready);
endinterface

// ----- hw/rtl/vprq_byte_store.sv -----
// ----------------------------------------------------------------------------
// vprq_byte_store
// circular byte store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module vprq_byte_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [vprq_pkg::BYTE_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [vprq_pkg::BYTE_W-1:0]  rd_data
);
  import vprq_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/variable_packet_ring_queue.sv -----
// ----------------------------------------------------------------------------
// variable_packet_ring_queue
// fifo of variable-length packets: bytes in a circular store, lengths in a
// ring of slot descriptors, one status word returned per command word
// ----------------------------------------------------------------------------
// flow: a command word is captured on accept and run in S_EXEC once the result
//   register is free; no word is taken before it runs, as the byte store and
//   slot memory are read on accept and written back when the word is executed
// reset: synchronous, active low; pointers, counts and end of stream clear,
//   the byte store and slot memory are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module variable_packet_ring_queue #(
  parameter int SLOT_COUNT  = 16,
  parameter int STORE_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  vprq_in_if.sink    in_ch,
  vprq_out_if.source out_ch
);
  import vprq_pkg::*;

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int PW    = $clog2(STORE_BYTES);
  localparam int HW    = $clog2(STORE_BYTES + 1);
  localparam int CMP_W = (HW > LEN_W) ? HW : LEN_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t            state_r;
  func_t             func_r;
  logic [BYTE_W-1:0] data_r;
  logic [LEN_W-1:0]  len_r;

  logic [SW-1:0]     slot_wr_r, slot_wr_nxt;
  logic [SW-1:0]     slot_rd_r, slot_rd_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [HW-1:0]     held_r, held_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [LEN_W-1:0]  rcnt_r, rcnt_nxt;
  logic              eos_r, eos_nxt;

  logic              out_valid_r;
  status_t           out_status_r, status_nxt;
  logic [BYTE_W-1:0] out_byte_r, rbyte_nxt;
  logic [LEN_W-1:0]  out_plen_r, plen_nxt;
  logic              out_last_r, last_nxt;

  logic [LEN_W-1:0]  slot_mem [SLOT_COUNT];
  logic [LEN_W-1:0]  sl_rdata_r;
  logic [BYTE_W-1:0] bs_rdata;

  logic              accept, exec_fire, bs_we, sl_we;
  logic [SW-1:0]     slot_wr_inc, slot_rd_inc;
  logic [PW-1:0]     wp_inc, rp_inc;
  logic [HW-1:0]     free_bytes;
  logic [CMP_W-1:0]  len_ext, free_ext, held_ext, plen_ext;
  logic [LEN_W-1:0]  rcnt_inc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign exec_fire   = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  assign slot_wr_inc = (slot_wr_r == SW'(SLOT_COUNT - 1)) ? '0 : slot_wr_r + SW'(1);
  assign slot_rd_inc = (slot_rd_r == SW'(SLOT_COUNT - 1)) ? '0 : slot_rd_r + SW'(1);
  assign wp_inc      = (wp_r == PW'(STORE_BYTES - 1)) ? '0 : wp_r + PW'(1);
  assign rp_inc      = (rp_r == PW'(STORE_BYTES - 1)) ? '0 : rp_r + PW'(1);
  assign free_bytes  = HW'(STORE_BYTES) - held_r;
  assign len_ext     = CMP_W'(len_r);
  assign free_ext    = CMP_W'(free_bytes);
  assign held_ext    = CMP_W'(held_r);
  assign plen_ext    = CMP_W'(sl_rdata_r);
  assign rcnt_inc    = rcnt_r + LEN_W'(1);

  // byte store
  vprq_byte_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (PW)
  ) u_store (
    .clk     (clk),
    .wr_en   (bs_we && exec_fire),
    .wr_addr (wp_r),
    .wr_data (data_r),
    .rd_en   (accept),
    .rd_addr (rp_r),
    .rd_data (bs_rdata)
  );

  // slot descriptor memory and command capture
  always_ff @(posedge clk) begin
    if (sl_we && exec_fire) begin
      slot_mem[slot_wr_r] <= len_r;
    end
    if (accept) begin
      sl_rdata_r <= slot_mem[slot_rd_r];
      func_r     <= in_ch.func;
      data_r     <= in_ch.data_byte;
      len_r      <= in_ch.packet_length;
    end
  end

  always_comb begin
    slot_wr_nxt = slot_wr_r;
    slot_rd_nxt = slot_rd_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    held_nxt    = held_r;
    left_nxt    = left_r;
    rcnt_nxt    = rcnt_r;
    eos_nxt     = eos_r;
    status_nxt  = ST_OK;
    rbyte_nxt   = '0;
    plen_nxt    = '0;
    last_nxt    = 1'b0;
    bs_we       = 1'b0;
    sl_we       = 1'b0;
    case (func_r)
      FN_OPEN: begin
        if (eos_r) begin
          status_nxt = ST_EOS;
        end else if (left_r != '0 || len_r == '0) begin
          status_nxt = ST_SEQ;
        end else if (slot_wr_inc == slot_rd_r) begin
          status_nxt = ST_NO_SLOT;
        end else if (len_ext > free_ext) begin
          status_nxt = ST_NO_SPACE;
        end else begin
          sl_we    = 1'b1;
          left_nxt = len_r;
        end
      end
      FN_PUSH: begin
        if (left_r == '0) begin
          status_nxt = ST_SEQ;
        end else begin
          bs_we    = 1'b1;
          wp_nxt   = wp_inc;
          held_nxt = held_r + HW'(1);
          left_nxt = left_r - LEN_W'(1);
          if (left_r == LEN_W'(1)) begin
            slot_wr_nxt = slot_wr_inc;
          end
        end
      end
      FN_POP: begin
        if (eos_r) begin
          status_nxt = ST_EOS;
        end else if (slot_wr_r == slot_rd_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          plen_nxt  = sl_rdata_r;
          rbyte_nxt = bs_rdata;
          rp_nxt    = rp_inc;
          if (rcnt_inc >= sl_rdata_r) begin
            last_nxt    = 1'b1;
            rcnt_nxt    = '0;
            slot_rd_nxt = slot_rd_inc;
            held_nxt    = (held_ext >= plen_ext) ? HW'(held_ext - plen_ext) : '0;
          end else begin
            rcnt_nxt = rcnt_inc;
          end
        end
      end
      FN_FINISH: begin
        eos_nxt = 1'b1;
      end
      default: begin
        status_nxt = ST_SEQ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_wr_r   <= '0;
      slot_rd_r   <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      held_r      <= '0;
      left_r      <= '0;
      rcnt_r      <= '0;
      eos_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (exec_fire) begin
        slot_wr_r    <= slot_wr_nxt;
        slot_rd_r    <= slot_rd_nxt;
        wp_r         <= wp_nxt;
        rp_r         <= rp_nxt;
        held_r       <= held_nxt;
        left_r       <= left_nxt;
        rcnt_r       <= rcnt_nxt;
        eos_r        <= eos_nxt;
        out_valid_r  <= 1'b1;
        out_status_r <= status_nxt;
        out_byte_r   <= rbyte_nxt;
        out_plen_r   <= plen_nxt;
        out_last_r   <= last_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.read_byte      = out_byte_r;
  assign out_ch.popped_length  = out_plen_r;
  assign out_ch.last_of_packet = out_last_r;

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(STORE_BYTES))
    else $error("bytes held beyond store size");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC) && $stable(rp_r) && $stable(slot_rd_r))
    else $error("read pointers moved before execute");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_valid_r && (state_r == S_IDLE))
    else $error("executed word gave no result");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_status_r == ST_OK) && (out_plen_r != '0))
    else $error("last byte flagged on a refused word");
`endif

endmodule
